[rtl/reply_quorum_collector_top_macros.svh]
// Assertion helpers shared by the RTL. The clock and reset are clk and arst_n.
`ifndef REPLY_QUORUM_COLLECTOR_TOP_MACROS_SVH
`define REPLY_QUORUM_COLLECTOR_TOP_MACROS_SVH

`ifndef SYNTH
`define RQC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define RQC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define RQC_ASSERT_SAME(lbl, ante, cons)
`define RQC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/rqc_pkg.sv]
package rqc_pkg;

	localparam int TAG_W    = 64;
	localparam int DIGEST_W = 64;
	localparam int VIEW_W   = 32;
	localparam int CLIENT_W = 16;
	localparam int REPL_W   = 5;
	localparam int COUNT_W  = 6;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [2:0] {
		ST_ISSUED   = 3'd0,
		ST_IGNORED  = 3'd1,
		ST_COUNTED  = 3'd2,
		ST_ACCEPTED = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLIENT_ID = 2'd0,
		REG_REPLICAS  = 2'd1
	} reg_idx_t;

	localparam logic [COUNT_W-1:0] QUORUM_RESET = 6'd2;

	// f+1 with f = (n-1)/3; the divide by three is a multiply by 43 and a shift,
	// exact for every six-bit value.
	function automatic logic [COUNT_W-1:0] quorum_of(input logic [COUNT_W-1:0] n);
		logic [COUNT_W-1:0] m;
		logic [12:0] p;
		m = n - 6'd1;
		p = 13'(m) * 13'd43;
		return 6'(p >> 7) + 6'd1;
	endfunction

endpackage

[rtl/rqc_ram.sv]
module rqc_ram #(
	parameter int WIDTH = 70,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[rtl/reply_quorum_collector_top.sv]
// An issue word passes the check state and a scan from slot 0 for the lowest free slot; then the
// emit state loads its result. A reply passes the check state, a tag scan over up to SLOTS slots,
// a read and compare in the candidate RAM per stored candidate digest, then adds a candidate if
// none matched, decides and loads the output register; the tag scan and candidate reads set its length.
// A new word is taken only in the idle state, entered as the result is loaded into a free output.
// Reset clears the sequencer, the slot busy bits, the tag counter, and sets the view to 1.
module reply_quorum_collector_top #(
	parameter int SLOTS        = 16,
	parameter int MAX_REPLICAS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rqc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [rqc_pkg::CLIENT_W-1:0]  reply_client,
	input  logic [rqc_pkg::REPL_W-1:0]    reply_replica,
	input  logic [rqc_pkg::VIEW_W-1:0]    reply_view,
	input  logic [rqc_pkg::TAG_W-1:0]     reply_tag,
	input  logic [rqc_pkg::DIGEST_W-1:0]  reply_digest,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [rqc_pkg::TAG_W-1:0]     tag,
	output logic [rqc_pkg::DIGEST_W-1:0]  accepted_digest,
	output logic [rqc_pkg::VIEW_W-1:0]    view_now
);
	import rqc_pkg::*;

	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int UW    = $clog2(MAX_REPLICAS + 1);
	localparam int DEPTH = SLOTS * MAX_REPLICAS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = DIGEST_W + UW;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_CHECK  = 8'b0000_0010,
		S_FREE   = 8'b0000_0100,
		S_SCAN   = 8'b0000_1000,
		S_CRD    = 8'b0001_0000,
		S_CCMP   = 8'b0010_0000,
		S_DECIDE = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [CLIENT_W-1:0] own_client_q;
	logic [COUNT_W-1:0]  replica_count_q;
	logic [COUNT_W-1:0]  quorum_q;

	logic [TAG_W-1:0]  next_tag_q;
	logic [VIEW_W-1:0] known_view_q;
	logic [SLOTS-1:0]  busy_q;
	logic [TAG_W-1:0]  slot_tag_q [SLOTS];
	logic [MAX_REPLICAS-1:0] seen_q [SLOTS];
	logic [UW-1:0]     used_cnt_q [SLOTS];

	logic                op_q;
	logic [CLIENT_W-1:0] client_q;
	logic [REPL_W-1:0]   replica_q;
	logic [VIEW_W-1:0]   view_q;
	logic [TAG_W-1:0]    rtag_q;
	logic [DIGEST_W-1:0] digest_q;

	logic [SW-1:0]  scan_q;
	logic [SW-1:0]  slot_q;
	logic [AW-1:0]  base_q;
	logic [UW-1:0]  used_q;
	logic [UW-1:0]  cidx_q;
	logic [UW-1:0]  votes_q;

	status_t             res_status_q;
	logic [TAG_W-1:0]    res_tag_q;
	logic [DIGEST_W-1:0] res_digest_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [RW-1:0] ram_rdata;

	logic                    scan_last;
	logic                    replica_bad;
	logic [MAX_REPLICAS-1:0] replica_bit;
	logic [DIGEST_W-1:0]     rd_digest;
	logic [UW-1:0]           rd_votes;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign scan_last = (scan_q == SW'(SLOTS - 1));
	assign replica_bit = MAX_REPLICAS'(1) << replica_q;
	assign replica_bad = ({1'b0, replica_q} >= replica_count_q) ||
		(32'(replica_q) >= 32'(MAX_REPLICAS)) ||
		((seen_q[scan_q] & replica_bit) != '0);
	assign rd_digest = ram_rdata[RW-1:UW];
	assign rd_votes  = ram_rdata[UW-1:0];
	assign ram_raddr = base_q + AW'(cidx_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = base_q + AW'(cidx_q);
		ram_wdata = {digest_q, rd_votes + UW'(1)};
		if (state_q == S_CRD) begin
			ram_we    = (cidx_q == used_q) && (32'(used_q) < 32'(MAX_REPLICAS));
			ram_wdata = {digest_q, UW'(1)};
		end else if (state_q == S_CCMP) begin
			ram_we = (rd_digest == digest_q);
		end
	end

	rqc_ram #(
		.WIDTH(RW),
		.DEPTH(DEPTH)
	) u_cand_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_client_q    <= '0;
			replica_count_q <= 6'd4;
			quorum_q        <= QUORUM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CLIENT_ID: own_client_q <= cfg_data[CLIENT_W-1:0];
				REG_REPLICAS: begin
					replica_count_q <= cfg_data[COUNT_W-1:0];
					quorum_q        <= quorum_of(cfg_data[COUNT_W-1:0]);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			next_tag_q   <= '0;
			known_view_q <= VIEW_W'(1);
			busy_q       <= '0;
			out_valid    <= 1'b0;
		end else begin
			// The emit state handles the output word itself.
			if (out_valid && out_ready && state_q != S_EMIT) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (!op_q) begin
						state_q <= S_FREE;
					end else if (client_q != own_client_q) begin
						state_q <= S_EMIT;
					end else begin
						if (view_q > known_view_q) begin
							known_view_q <= view_q;
						end
						state_q <= S_SCAN;
					end
				end
				S_FREE: begin
					if (!busy_q[scan_q]) begin
						next_tag_q     <= next_tag_q + TAG_W'(1);
						busy_q[scan_q] <= 1'b1;
						state_q        <= S_EMIT;
					end else if (scan_last) begin
						state_q <= S_EMIT;
					end
				end
				S_SCAN: begin
					if (busy_q[scan_q] && slot_tag_q[scan_q] == rtag_q) begin
						state_q <= replica_bad ? S_EMIT : S_CRD;
					end else if (scan_last) begin
						state_q <= S_EMIT;
					end
				end
				S_CRD: begin
					if (cidx_q == used_q) begin
						state_q <= ram_we ? S_DECIDE : S_EMIT;
					end else begin
						state_q <= S_CCMP;
					end
				end
				S_CCMP: begin
					state_q <= ram_we ? S_DECIDE : S_CRD;
				end
				S_DECIDE: begin
					if (votes_q >= UW'(quorum_q)) begin
						busy_q[slot_q] <= 1'b0;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath and per-slot payload; allocation clears a slot's vote state.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q      <= opcode;
				client_q  <= reply_client;
				replica_q <= reply_replica;
				view_q    <= reply_view;
				rtag_q    <= reply_tag;
				digest_q  <= reply_digest;
				scan_q    <= '0;
			end
			S_CHECK: begin
				res_status_q <= ST_IGNORED;
				res_tag_q    <= rtag_q;
				res_digest_q <= '0;
				if (!op_q) begin
					res_status_q <= ST_FULL;
					res_tag_q    <= '0;
				end
			end
			S_FREE: begin
				if (!busy_q[scan_q]) begin
					slot_tag_q[scan_q] <= next_tag_q + TAG_W'(1);
					seen_q[scan_q]     <= '0;
					used_cnt_q[scan_q] <= '0;
					res_status_q       <= ST_ISSUED;
					res_tag_q          <= next_tag_q + TAG_W'(1);
				end else begin
					scan_q <= scan_q + SW'(1);
				end
			end
			S_SCAN: begin
				if (busy_q[scan_q] && slot_tag_q[scan_q] == rtag_q) begin
					slot_q <= scan_q;
					base_q <= AW'(scan_q) * AW'(MAX_REPLICAS);
					used_q <= used_cnt_q[scan_q];
					cidx_q <= '0;
					if (!replica_bad) begin
						seen_q[scan_q] <= seen_q[scan_q] | replica_bit;
					end
				end else begin
					scan_q <= scan_q + SW'(1);
				end
			end
			S_CRD: begin
				if (cidx_q == used_q) begin
					res_status_q <= ST_COUNTED;
					votes_q      <= UW'(1);
					if (ram_we) begin
						used_cnt_q[slot_q] <= used_q + UW'(1);
					end
				end
			end
			S_CCMP: begin
				if (ram_we) begin
					votes_q <= rd_votes + UW'(1);
				end else begin
					cidx_q <= cidx_q + UW'(1);
				end
			end
			S_DECIDE: begin
				res_status_q <= ST_COUNTED;
				if (votes_q >= UW'(quorum_q)) begin
					res_status_q <= ST_ACCEPTED;
					res_digest_q <= digest_q;
				end
			end
			S_EMIT: begin
				if (!out_valid || out_ready) begin
					status          <= res_status_q;
					tag             <= res_tag_q;
					accepted_digest <= res_digest_q;
					view_now        <= known_view_q;
				end
			end
			default: ;
		endcase
	end

	`include "reply_quorum_collector_top_macros.svh"

	`RQC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`RQC_ASSERT_SAME(a_digest_only_on_accept, out_valid && status != ST_ACCEPTED, accepted_digest == '0)
	`RQC_ASSERT_SAME(a_full_tag_zero, out_valid && status == ST_FULL, tag == '0)
	`RQC_ASSERT_SAME(a_view_monotonic, $past(arst_n), known_view_q >= $past(known_view_q))

endmodule
